/* design/smb_pkg.sv */
// Shared types and constants for the mesh boundary Laplacian smoother.
// Used by smb_div and the top level; depends on nothing.
package smb_pkg;

  // Index widths follow the store depths
  localparam int unsigned MAX_NODES       = 1024;
  localparam int unsigned MAX_FACES       = 2048;
  localparam int unsigned NODE_AW         = $clog2(MAX_NODES);
  localparam int unsigned FACE_AW         = $clog2(MAX_FACES);
  localparam int unsigned CHECK_START_DEF = 3;

  localparam int unsigned VAL_W      = 32;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned CNT_W      = 14;
  localparam int unsigned DEN_W      = CNT_W + 1;
  localparam int unsigned FACE_W     = 3 * NODE_AW;
  localparam int unsigned ITER_W     = 8;
  localparam int unsigned NCNT_W     = 11;
  localparam int unsigned FCNT_W     = 12;
  localparam int unsigned Q8_W       = 16;
  localparam int unsigned ACC_W      = VAL_W + 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FACE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd4;

  typedef enum logic [1:0] {
    REQ_LOAD_NODE = 2'd0,
    REQ_LOAD_FACE = 2'd1,
    REQ_RUN       = 2'd2,
    REQ_READ      = 2'd3
  } req_e;

  typedef enum logic {
    RES_RUN  = 1'b0,
    RES_READ = 1'b1
  } res_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [9:0]              node_index;
    logic signed [VAL_W-1:0] node_value;
    logic [10:0]             face_index;
    logic [9:0]              corner_a;
    logic [9:0]              corner_b;
    logic [9:0]              corner_c;
  } in_req_t;

  typedef struct packed {
    logic                    result_kind;
    logic [ITER_W-1:0]       passes_done;
    logic signed [VAL_W-1:0] value_out;
  } out_res_t;

  // Divider request: floor(num / den), den nonzero
  typedef struct packed {
    logic signed [SUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_CLR,
    ST_CF_RD, ST_CF_LAT, ST_CC_RD, ST_CC_WR,
    ST_SF_RD, ST_SF_LAT, ST_SV_RD, ST_SV_ACC, ST_SS_RD, ST_SS_WR,
    ST_U_RD, ST_U_MUL, ST_U_SUB, ST_U_DST, ST_U_DIV, ST_U_WR,
    ST_E_CHK,
    ST_LF_RD, ST_LF_LAT, ST_LV_RD, ST_LV_ACC, ST_L_CMP,
    ST_NEXT, ST_DONE
  } state_e;

endpackage

/* design/smb_ram.sv */
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on nothing; one instance per state store of the smoother.
module smb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/smb_div.sv */
// Radix-2 restoring divider giving floor(num / den) for a signed numerator.
// Depends on smb_pkg; one quotient bit per cycle.
module smb_div import smb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  div_req_t                req_i,
  output logic                    done_o,
  output logic signed [SUM_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W);

  logic                    busy_q, fin_q, done_q, neg_q;
  logic [STEP_W-1:0]       step_q;
  logic [SUM_W-1:0]        mag_q;
  logic [DEN_W-1:0]        den_q;
  logic [DEN_W-1:0]        rem_q;
  logic signed [SUM_W-1:0] quot_q;
  logic [DEN_W:0]          shifted;
  logic                    ge;
  logic [DEN_W-1:0]        rem_d;

  // One restoring step
  always_comb begin
    shifted = {rem_q, mag_q[SUM_W-1]};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // Operand and quotient registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= req_i.num[SUM_W-1];
      mag_q <= req_i.num[SUM_W-1] ? SUM_W'(-req_i.num) : SUM_W'(req_i.num);
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[SUM_W-2:0], ge};
      rem_q <= rem_d;
    end
    // Floor: a negative inexact quotient rounds one further down
    if (fin_q) begin
      if (!neg_q) begin
        quot_q <= $signed(mag_q);
      end else if (rem_q != '0) begin
        quot_q <= $signed(~mag_q);
      end else begin
        quot_q <= $signed(SUM_W'(-mag_q));
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q && !fin_q)
    else $error("divider restarted while busy");

  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(fin_q))
    else $error("divider done without a final step");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= STEP_W'(SUM_W - 1))
    else $error("divider step count out of range");

endmodule

/* design/mesh_boundary_laplacian_smoother.sv */
// Top level of the mesh Laplacian smoother: request decode, run sequencer,
// the four state memories and the output register. Depends on smb_pkg,
// smb_ram and smb_div.
//
// Usage: requests enter on in_valid_i / in_stall_o carrying in_req_i; results
// leave on out_valid_o / out_stall_i carrying out_res_o. Registers are written
// through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only
// while the block is idle, as the block does not enforce it. A node or face
// load gives no result. A node read is issued from idle and its value is
// registered into the output register in ST_READ. A run first sweeps all
// MAX_NODES entries of the count and sum memories, then counts face
// incidences. Each pass sums corner values per face into the sum memory,
// updates each node in use through the shared divider (a node on no face is
// skipped) and may add a limit scan over the faces. The node memory has a
// single read port and the divider is bit-serial.
// One request is worked on at a time. The output register holds a result
// while out_stall_i is high; new requests are taken only when that register
// is free or being emptied. Reset clears the configuration and control
// registers; datapath and memory contents are undefined until written.
module mesh_boundary_laplacian_smoother import smb_pkg::*; #(
  parameter int unsigned CHECK_START = CHECK_START_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_req_t               in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_res_t              out_res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration
  logic [ITER_W-1:0] max_iter_q;
  logic [NCNT_W-1:0] nc_q;
  logic [FCNT_W-1:0] fc_q;
  logic [Q8_W-1:0]   limit_q, tol_q;

  // Control
  state_e            state_q, state_d;
  logic [FCNT_W-1:0] f_q;
  logic [NCNT_W-1:0] n_q;
  logic [1:0]        k_q;
  logic [ITER_W-1:0] iter_q;
  logic              more_q;
  logic [VAL_W-1:0]  largest_q, ref_q;
  logic              out_valid_q;

  // Datapath
  logic [FACE_W-1:0]       face_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [VAL_W-1:0] u_q, hi_q, lo_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [SUM_W-1:0] sum_q, prod_q, num_q;
  out_res_t                out_res_q;

  // Memory ports
  logic                    v_we, v_re, f_we, f_re, c_we, c_re, s_we, s_re;
  logic [NODE_AW-1:0]      v_wa, v_ra, c_wa, c_ra, s_wa, s_ra;
  logic [FACE_AW-1:0]      f_wa, f_ra;
  logic [VAL_W-1:0]        v_wd, v_rd;
  logic [FACE_W-1:0]       f_wd, f_rd;
  logic [CNT_W-1:0]        c_wd, c_rd;
  logic [SUM_W-1:0]        s_wd, s_rd;

  // Divider
  logic                    div_start, div_done;
  div_req_t                div_req;
  logic signed [SUM_W-1:0] quot;

  logic                    in_acc;
  logic [NODE_AW-1:0]      crn;
  logic [ITER_W-1:0]       chk_at;
  logic [VAL_W-1:0]        ref_eff, mag, new_val;
  logic [SUM_W-1:0]        tol_prod;
  logic                    tol_more, face_fail;
  logic signed [SUM_W-2:0] prod_mul;
  logic signed [49:0]      lim_lhs, lim_rhs;
  logic [NCNT_W-1:0]       nc_sat;
  logic [FCNT_W-1:0]       fc_sat;

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // Corner selected by k
  always_comb begin
    case (k_q)
      2'd0:    crn = face_q[3*NODE_AW-1:2*NODE_AW];
      2'd1:    crn = face_q[2*NODE_AW-1:NODE_AW];
      default: crn = face_q[NODE_AW-1:0];
    endcase
  end

  // Arithmetic of the update, convergence and limit checks
  always_comb begin
    chk_at    = (max_iter_q < ITER_W'(CHECK_START)) ? max_iter_q : ITER_W'(CHECK_START);
    ref_eff   = (iter_q == ITER_W'(1)) ? largest_q : ref_q;
    tol_prod  = SUM_W'(tol_q * ref_eff);
    tol_more  = {8'd0, largest_q, 8'd0} > tol_prod;
    prod_mul  = $signed({1'b0, c_rd}) * $signed(v_rd);
    mag       = quot[SUM_W-1] ? VAL_W'(~quot[VAL_W-1:0] + 1'b1) : quot[VAL_W-1:0];
    new_val   = VAL_W'(u_q + quot[VAL_W-1:0]);
    lim_lhs   = {{10{hi_q[VAL_W-1]}}, hi_q, 8'd0};
    lim_rhs   = $signed({1'b0, 17'(17'd256 + limit_q)}) * lo_q;
    face_fail = lim_lhs > lim_rhs;
    nc_sat    = (cfg_data_i[NCNT_W-1:0] > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES)
                                                               : cfg_data_i[NCNT_W-1:0];
    fc_sat    = (cfg_data_i[FCNT_W-1:0] > FCNT_W'(MAX_FACES)) ? FCNT_W'(MAX_FACES)
                                                               : cfg_data_i[FCNT_W-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_req_i.req_type)
            REQ_RUN:  state_d = (max_iter_q == '0) ? ST_DONE : ST_CLR;
            REQ_READ: state_d = ST_READ;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:   state_d = ST_IDLE;
      ST_CLR:    if (n_q == NCNT_W'(MAX_NODES - 1)) state_d = ST_CF_RD;
      ST_CF_RD:  state_d = (f_q == fc_q) ? ST_SF_RD : ST_CF_LAT;
      ST_CF_LAT: state_d = ST_CC_RD;
      ST_CC_RD:  state_d = ST_CC_WR;
      ST_CC_WR:  state_d = (k_q == 2'd2) ? ST_CF_RD : ST_CC_RD;
      ST_SF_RD:  state_d = (f_q == fc_q) ? ST_U_RD : ST_SF_LAT;
      ST_SF_LAT: state_d = ST_SV_RD;
      ST_SV_RD:  state_d = ST_SV_ACC;
      ST_SV_ACC: state_d = (k_q == 2'd2) ? ST_SS_RD : ST_SV_RD;
      ST_SS_RD:  state_d = ST_SS_WR;
      ST_SS_WR:  state_d = (k_q == 2'd2) ? ST_SF_RD : ST_SS_RD;
      ST_U_RD:   state_d = (n_q == nc_q) ? ST_E_CHK : ST_U_MUL;
      ST_U_MUL:  state_d = (c_rd == '0) ? ST_U_RD : ST_U_SUB;
      ST_U_SUB:  state_d = ST_U_DST;
      ST_U_DST:  state_d = ST_U_DIV;
      ST_U_DIV:  if (div_done) state_d = ST_U_WR;
      ST_U_WR:   state_d = ST_U_RD;
      ST_E_CHK: begin
        if (iter_q > chk_at && tol_more && limit_q != '0) state_d = ST_LF_RD;
        else state_d = ST_NEXT;
      end
      ST_LF_RD:  state_d = (f_q == fc_q) ? ST_NEXT : ST_LF_LAT;
      ST_LF_LAT: state_d = ST_LV_RD;
      ST_LV_RD:  state_d = ST_LV_ACC;
      ST_LV_ACC: state_d = (k_q == 2'd2) ? ST_L_CMP : ST_LV_RD;
      ST_L_CMP:  state_d = face_fail ? ST_NEXT : ST_LF_RD;
      ST_NEXT:   state_d = (more_q && iter_q < max_iter_q) ? ST_SF_RD : ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory and divider controls
  always_comb begin
    v_we = 1'b0; v_wa = n_q[NODE_AW-1:0]; v_wd = new_val;
    v_re = 1'b0; v_ra = crn;
    f_we = 1'b0; f_wa = in_req_i.face_index;
    f_wd = {in_req_i.corner_a, in_req_i.corner_b, in_req_i.corner_c};
    f_re = 1'b0; f_ra = f_q[FACE_AW-1:0];
    c_we = 1'b0; c_wa = n_q[NODE_AW-1:0]; c_wd = '0;
    c_re = 1'b0; c_ra = crn;
    s_we = 1'b0; s_wa = n_q[NODE_AW-1:0]; s_wd = '0;
    s_re = 1'b0; s_ra = crn;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_req_i.req_type)
            REQ_LOAD_NODE: begin
              v_we = 1'b1;
              v_wa = in_req_i.node_index;
              v_wd = in_req_i.node_value;
            end
            REQ_LOAD_FACE: f_we = 1'b1;
            REQ_READ: begin
              v_re = 1'b1;
              v_ra = in_req_i.node_index;
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        c_we = 1'b1;
        s_we = 1'b1;
      end
      ST_CF_RD, ST_SF_RD, ST_LF_RD: f_re = 1'b1;
      ST_CC_RD: c_re = 1'b1;
      ST_CC_WR: begin
        c_we = 1'b1;
        c_wa = crn;
        c_wd = CNT_W'(c_rd + 2'd3);
      end
      ST_SV_RD, ST_LV_RD: v_re = 1'b1;
      ST_SS_RD: s_re = 1'b1;
      ST_SS_WR: begin
        s_we = 1'b1;
        s_wa = crn;
        s_wd = SUM_W'($signed(s_rd) + acc_q);
      end
      ST_U_RD: begin
        v_re = 1'b1; v_ra = n_q[NODE_AW-1:0];
        c_re = 1'b1; c_ra = n_q[NODE_AW-1:0];
        s_re = 1'b1; s_ra = n_q[NODE_AW-1:0];
      end
      ST_U_DST: div_start = 1'b1;
      ST_U_WR: begin
        // New value, and the sum is cleared for the next pass
        v_we = 1'b1;
        s_we = 1'b1;
      end
      default: ;
    endcase
  end

  assign div_req.num = num_q;
  assign div_req.den = {cnt_q, 1'b0};

  // Configuration, counters and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q  <= '0;
      nc_q        <= '0;
      fc_q        <= '0;
      limit_q     <= '0;
      tol_q       <= '0;
      state_q     <= ST_IDLE;
      f_q         <= '0;
      n_q         <= '0;
      k_q         <= '0;
      iter_q      <= '0;
      more_q      <= 1'b0;
      largest_q   <= '0;
      ref_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_ITER:   max_iter_q <= cfg_data_i[ITER_W-1:0];
          CFG_NODE_COUNT: nc_q       <= nc_sat;
          CFG_FACE_COUNT: fc_q       <= fc_sat;
          CFG_LIMIT:      limit_q    <= cfg_data_i;
          CFG_TOLERANCE:  tol_q      <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == ST_READ || state_q == ST_DONE) out_valid_q <= 1'b1;

      case (state_q)
        ST_IDLE: begin
          if (in_acc && in_req_i.req_type == REQ_RUN) begin
            iter_q <= (max_iter_q == '0) ? '0 : ITER_W'(1);
            n_q    <= '0;
          end
        end
        ST_CLR: begin
          n_q <= n_q + 1'b1;
          f_q <= '0;
        end
        ST_CF_RD: begin
          if (f_q == fc_q) begin
            f_q       <= '0;
            largest_q <= '0;
          end
        end
        ST_CF_LAT, ST_SF_LAT, ST_LF_LAT: k_q <= '0;
        ST_CC_WR, ST_SS_WR: begin
          if (k_q == 2'd2) begin
            k_q <= '0;
            f_q <= f_q + 1'b1;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_SV_ACC, ST_LV_ACC: k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
        ST_SF_RD: if (f_q == fc_q) n_q <= '0;
        ST_U_MUL: if (c_rd == '0) n_q <= n_q + 1'b1;
        ST_U_WR: begin
          n_q <= n_q + 1'b1;
          if (mag > largest_q) largest_q <= mag;
        end
        ST_E_CHK: begin
          if (iter_q == ITER_W'(1)) ref_q <= largest_q;
          more_q <= (iter_q > chk_at) ? tol_more : 1'b1;
          f_q    <= '0;
        end
        ST_LF_RD: if (f_q == fc_q) more_q <= 1'b0;
        ST_L_CMP: begin
          if (face_fail) more_q <= 1'b1;
          else f_q <= f_q + 1'b1;
        end
        ST_NEXT: begin
          if (more_q && iter_q < max_iter_q) begin
            iter_q    <= iter_q + 1'b1;
            largest_q <= '0;
            f_q       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q) inside
      ST_CF_LAT, ST_LF_LAT: face_q <= f_rd;
      ST_SF_LAT: begin
        face_q <= f_rd;
        acc_q  <= '0;
      end
      ST_SV_ACC: acc_q <= acc_q + ACC_W'($signed(v_rd));
      ST_U_MUL: begin
        u_q    <= v_rd;
        cnt_q  <= c_rd;
        sum_q  <= s_rd;
        prod_q <= SUM_W'(prod_mul);
      end
      ST_U_SUB: num_q <= sum_q - prod_q;
      ST_LV_ACC: begin
        if (k_q == 2'd0) begin
          hi_q <= v_rd;
          lo_q <= v_rd;
        end else begin
          if ($signed(v_rd) > hi_q) hi_q <= v_rd;
          if ($signed(v_rd) < lo_q) lo_q <= v_rd;
        end
      end
      ST_READ: begin
        out_res_q.result_kind <= RES_READ;
        out_res_q.passes_done <= '0;
        out_res_q.value_out   <= v_rd;
      end
      ST_DONE: begin
        out_res_q.result_kind <= RES_RUN;
        out_res_q.passes_done <= iter_q;
        out_res_q.value_out   <= '0;
      end
      default: ;
    endcase
  end

  smb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd),
    .re_i(v_re), .raddr_i(v_ra), .rdata_o(v_rd)
  );

  smb_ram #(.WIDTH(FACE_W), .DEPTH(MAX_FACES)) u_face_ram (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd),
    .re_i(f_re), .raddr_i(f_ra), .rdata_o(f_rd)
  );

  smb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_count_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd),
    .re_i(c_re), .raddr_i(c_ra), .rdata_o(c_rd)
  );

  smb_ram #(.WIDTH(SUM_W), .DEPTH(MAX_NODES)) u_sum_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd),
    .re_i(s_re), .raddr_i(s_ra), .rdata_o(s_rd)
  );

  smb_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .req_i(div_req),
    .done_o(div_done), .quot_o(quot)
  );

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == ST_IDLE)
    else $error("request taken while busy");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_READ || state_q == ST_DONE))
    else $error("result raised outside read or run end");

  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_E_CHK |-> iter_q != '0 && iter_q <= max_iter_q)
    else $error("pass count out of range");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_U_DIV)
    else $error("divider finished outside the wait state");

endmodule
